/* rtl/ffls_pkg.sv */
// ----------------------------------------------------------------------------
// ffls_pkg: shared types and constants for the flat face shading block
// Widths of the fixed-point datapath, pipeline stage positions, register
// indexes and reset values of the control registers.
// ----------------------------------------------------------------------------
package ffls_pkg;

   // field widths
   localparam int VTX_W    = 16;   // vertex coordinate, signed Q4.12
   localparam int LIGHT_W  = 14;   // light component, signed Q1.12
   localparam int BRIGHT_W = 13;   // brightness / ambient floor
   localparam int CSR_IDX_W = 2;

   localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = {BRIGHT_W{1'b1}};

   // datapath widths
   localparam int EDGE_W  = VTX_W + 1;      // vertex difference
   localparam int ESQ_W   = 2 * EDGE_W;     // square of one edge component
   localparam int ESUM_W  = 34;             // squared edge length
   localparam int FRAC_SH = 28;             // scale applied before the root

   localparam int SQ_IN_W   = 62;
   localparam int SQ_OUT_W  = SQ_IN_W / 2;
   localparam int SQ_STAGES = SQ_IN_W / 2;
   localparam int SQ_W      = SQ_IN_W + 1;

   localparam int DV_NUM_W  = 47;
   localparam int DV_DEN_W  = 32;
   localparam int DV_Q_W    = 16;
   localparam int DV_REM_W  = DV_NUM_W + 1;
   localparam int DV_STAGES = DV_Q_W;
   localparam int QUO_W     = DV_Q_W + 1;

   localparam int XP_W  = 2 * QUO_W;        // cross product partial term
   localparam int CRS_W = 32;               // cross product component, Q3.28
   localparam int CSQ_W = 62;               // squared normal length
   localparam int DOT_W = CRS_W + LIGHT_W;  // one term of normal . light
   localparam int NUM_W = DV_NUM_W;         // normal . light

   // stage positions (register index, 0 = first register after accept)
   localparam int ST_EDGE = 0;
   localparam int ST_ESQ  = ST_EDGE + 1;
   localparam int ST_ESUM = ST_ESQ + 1;
   localparam int ST_ROOT1 = ST_ESUM + SQ_STAGES;
   localparam int ST_UNIT  = ST_ROOT1 + DV_STAGES;
   localparam int ST_XP   = ST_UNIT + 1;
   localparam int ST_XD   = ST_XP + 1;
   localparam int ST_QM   = ST_XD + 1;
   localparam int ST_QS   = ST_QM + 1;
   localparam int ST_ROOT2 = ST_QS + SQ_STAGES;
   localparam int ST_SHADE = ST_ROOT2 + DV_STAGES;
   localparam int ST_OUT  = ST_SHADE + 1;
   localparam int LAT     = ST_OUT + 1;

   typedef logic signed [EDGE_W-1:0] edge_type;
   typedef logic signed [QUO_W-1:0]  quo_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_X = 2'd0,
      CSR_LIGHT_Y = 2'd1,
      CSR_LIGHT_Z = 2'd2,
      CSR_AMBIENT = 2'd3
   } csr_index_type;

   localparam logic signed [LIGHT_W-1:0] LIGHT_X_RST = 14'sd0;
   localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RST = 14'sd4096;
   localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST = 14'sd4096;
   localparam logic [BRIGHT_W-1:0]       AMBIENT_RST = 13'd410;

endpackage

/* rtl/flat_face_lambert_shade.sv */
// ----------------------------------------------------------------------------
// flat_face_lambert_shade: flat Lambert shading, one triangle per transfer
// Normalizes both edges from the first vertex, crosses them, normalizes
// the face normal and dots it with the light direction, then clamps.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one triangle per transfer (valid/ready), vertices in Q4.12.
//   rsp_*  : one brightness (Q1.12) and a degenerate flag per triangle,
//            in the order the triangles came in.
//   csr_*  : write-only light direction and ambient floor; write them only
//            while the pipeline is empty.
// Throughput: one triangle per cycle while the receiver keeps up. The two
//   square roots (31 stages each, one root bit per stage) and the two
//   dividers (16 stages each, one quotient bit per stage) set the depth.
// Reset: clears every valid bit and the skid stage and loads the light
//   (0, 1.0, 1.0) and ambient floor 410; no clearing pass is needed.
// Stall: while rsp_ready is low a waiting result moves into a skid
//   register; the pipeline then freezes with req_ready low until the
//   skid result is transferred. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module flat_face_lambert_shade import ffls_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [VTX_W-1:0]     req_a_x,
   input  logic signed [VTX_W-1:0]     req_a_y,
   input  logic signed [VTX_W-1:0]     req_a_z,
   input  logic signed [VTX_W-1:0]     req_b_x,
   input  logic signed [VTX_W-1:0]     req_b_y,
   input  logic signed [VTX_W-1:0]     req_b_z,
   input  logic signed [VTX_W-1:0]     req_c_x,
   input  logic signed [VTX_W-1:0]     req_c_y,
   input  logic signed [VTX_W-1:0]     req_c_z,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [BRIGHT_W-1:0]         rsp_brightness,
   output logic                        rsp_degenerate,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [LIGHT_W-1:0]          csr_wdata
);

   // ---------------------------------------------------------------- csr
   logic signed [LIGHT_W-1:0] light_x_ff, light_y_ff, light_z_ff;
   logic [BRIGHT_W-1:0]       ambient_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= LIGHT_X_RST;
         light_y_ff <= LIGHT_Y_RST;
         light_z_ff <= LIGHT_Z_RST;
         ambient_ff <= AMBIENT_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LIGHT_X: light_x_ff <= csr_wdata;
            CSR_LIGHT_Y: light_y_ff <= csr_wdata;
            CSR_LIGHT_Z: light_z_ff <= csr_wdata;
            CSR_AMBIENT: ambient_ff <= csr_wdata[BRIGHT_W-1:0];
            default:     ;
         endcase
      end
   end

   // ------------------------------------------------------ flow control
   // The whole pipeline advances together; it only holds while the skid
   // register is occupied, so req_ready comes straight from a flop.
   logic                en;
   logic                skid_vld_ff;
   logic [BRIGHT_W-1:0] skid_bright_ff;
   logic                skid_degen_ff;
   logic                vld_ff [LAT];
   logic                deg_ff [LAT];

   assign en        = !skid_vld_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // ------------------------------------------------ edges and lengths
   edge_type            e_in [6];
   edge_type            e_ff [6];
   edge_type            e_b_ff [6];
   edge_type            e_c_ff [6];
   logic [ESQ_W-1:0]    esq_ff [6];
   logic [ESUM_W-1:0]   esum_in [2];
   logic [ESUM_W-1:0]   esum_ff [2];
   logic                edeg_in;

   always_comb begin
      e_in[0] = EDGE_W'(req_b_x) - EDGE_W'(req_a_x);
      e_in[1] = EDGE_W'(req_b_y) - EDGE_W'(req_a_y);
      e_in[2] = EDGE_W'(req_b_z) - EDGE_W'(req_a_z);
      e_in[3] = EDGE_W'(req_c_x) - EDGE_W'(req_a_x);
      e_in[4] = EDGE_W'(req_c_y) - EDGE_W'(req_a_y);
      e_in[5] = EDGE_W'(req_c_z) - EDGE_W'(req_a_z);
      esum_in[0] = ESUM_W'(esq_ff[0]) + ESUM_W'(esq_ff[1]) + ESUM_W'(esq_ff[2]);
      esum_in[1] = ESUM_W'(esq_ff[3]) + ESUM_W'(esq_ff[4]) + ESUM_W'(esq_ff[5]);
      edeg_in    = (esum_in[0] == '0) || (esum_in[1] == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            e_ff[i]   <= e_in[i];
            esq_ff[i] <= ESQ_W'(e_ff[i]) * ESQ_W'(e_ff[i]);
            e_b_ff[i] <= e_ff[i];
            e_c_ff[i] <= e_b_ff[i];
         end
         esum_ff[0] <= esum_in[0];
         esum_ff[1] <= esum_in[1];
      end
   end

   // ----------------------------------------------- edge normalization
   logic [SQ_OUT_W-1:0] elen [2];
   edge_type            e_dly_ff [SQ_STAGES][6];
   quo_type             unit [6];

   genvar g;
   generate
      for (g = 0; g < 2; g++) begin : g_elen
         ffls_isqrt u_elen (
            .clock (clock),
            .en    (en),
            .x_in  ({esum_ff[g], {FRAC_SH{1'b0}}}),
            .root  (elen[g])
         );
      end
   endgenerate

   // hold the edge components beside the root pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         e_dly_ff[0] <= e_c_ff;
         for (int s = 1; s < SQ_STAGES; s++) e_dly_ff[s] <= e_dly_ff[s-1];
      end
   end

   generate
      for (g = 0; g < 6; g++) begin : g_unit
         edge_type            ecomp;
         edge_type            emag;
         logic [DV_DEN_W-1:0] eden;

         // a zero-length edge is flagged; divide by one to keep it defined
         always_comb begin
            ecomp = e_dly_ff[SQ_STAGES-1][g];
            emag  = ecomp[EDGE_W-1] ? -ecomp : ecomp;
            eden  = (elen[g/3] == '0) ? DV_DEN_W'(1) : DV_DEN_W'(elen[g/3]);
         end

         ffls_div u_unit (
            .clock (clock),
            .en    (en),
            .num   (DV_NUM_W'({emag, {FRAC_SH{1'b0}}})),
            .den   (eden),
            .neg   (ecomp[EDGE_W-1]),
            .quo   (unit[g])
         );
      end
   endgenerate

   // ---------------------------------------------------- face normal
   logic signed [XP_W-1:0]  xp_ff [6];
   logic signed [CRS_W-1:0] crs_ff [3];
   logic signed [63:0]      csq_full [3];
   logic [CSQ_W-1:0]        csq_ff [3];
   logic signed [DOT_W-1:0] dot_in [3];
   logic signed [DOT_W-1:0] dot_ff [3];
   logic [CSQ_W-1:0]        nsq_in;
   logic [CSQ_W-1:0]        nsq_ff;
   logic signed [NUM_W-1:0] num_in;
   logic signed [NUM_W-1:0] num_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) csq_full[j] = crs_ff[j] * crs_ff[j];
      dot_in[0] = crs_ff[0] * light_x_ff;
      dot_in[1] = crs_ff[1] * light_y_ff;
      dot_in[2] = crs_ff[2] * light_z_ff;
      nsq_in = csq_ff[0] + csq_ff[1] + csq_ff[2];
      num_in = NUM_W'(dot_ff[0]) + NUM_W'(dot_ff[1]) + NUM_W'(dot_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xp_ff[0] <= unit[1] * unit[5];
         xp_ff[1] <= unit[2] * unit[4];
         xp_ff[2] <= unit[2] * unit[3];
         xp_ff[3] <= unit[0] * unit[5];
         xp_ff[4] <= unit[0] * unit[4];
         xp_ff[5] <= unit[1] * unit[3];
         for (int j = 0; j < 3; j++) begin
            crs_ff[j] <= CRS_W'(xp_ff[2*j] - xp_ff[2*j+1]);
            csq_ff[j] <= csq_full[j][CSQ_W-1:0];
            dot_ff[j] <= dot_in[j];
         end
         nsq_ff <= nsq_in;
         num_ff <= num_in;
      end
   end

   // degenerate flag travels with the item; set for a zero-length edge or a
   // normal that crosses to exactly zero
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LAT; i++) begin
            if (i == ST_ESUM)      deg_ff[i] <= edeg_in;
            else if (i == ST_QS)   deg_ff[i] <= deg_ff[i-1] | (nsq_in == '0);
            else if (i == 0)       deg_ff[i] <= 1'b0;
            else                   deg_ff[i] <= deg_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------ shading
   logic [SQ_OUT_W-1:0]     nlen;
   logic signed [NUM_W-1:0] num_dly_ff [SQ_STAGES];
   logic signed [NUM_W-1:0] nmag;
   logic                    nneg;
   logic [DV_DEN_W-1:0]     nden;
   quo_type                 shade;

   ffls_isqrt u_nlen (
      .clock (clock),
      .en    (en),
      .x_in  (nsq_ff),
      .root  (nlen)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         num_dly_ff[0] <= num_ff;
         for (int s = 1; s < SQ_STAGES; s++) num_dly_ff[s] <= num_dly_ff[s-1];
      end
   end

   always_comb begin
      nneg = num_dly_ff[SQ_STAGES-1][NUM_W-1];
      nmag = nneg ? -num_dly_ff[SQ_STAGES-1] : num_dly_ff[SQ_STAGES-1];
      nden = (nlen == '0) ? DV_DEN_W'(1) : DV_DEN_W'(nlen);
   end

   ffls_div u_shade (
      .clock (clock),
      .en    (en),
      .num   (DV_NUM_W'(nmag)),
      .den   (nden),
      .neg   (nneg),
      .quo   (shade)
   );

   // ---------------------------------------------------- clamp, output
   logic [BRIGHT_W-1:0] bright_in;
   logic [BRIGHT_W-1:0] bright_ff;
   logic                degen_ff;

   always_comb begin
      if (deg_ff[ST_SHADE])
         bright_in = ambient_ff;
      else if (shade < $signed({{(QUO_W-BRIGHT_W){1'b0}}, ambient_ff}))
         bright_in = ambient_ff;
      else if (shade > $signed({{(QUO_W-BRIGHT_W){1'b0}}, BRIGHT_MAX}))
         bright_in = BRIGHT_MAX;
      else
         bright_in = shade[BRIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bright_ff <= bright_in;
         degen_ff  <= deg_ff[ST_SHADE];
      end
   end

   // skid: take the waiting result when the receiver stalls, drop it
   // once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (en) begin
         skid_vld_ff <= vld_ff[ST_OUT] && !rsp_ready;
      end else if (rsp_ready) begin
         skid_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         skid_bright_ff <= bright_ff;
         skid_degen_ff  <= degen_ff;
      end
   end

   assign rsp_valid      = skid_vld_ff | vld_ff[ST_OUT];
   assign rsp_brightness = skid_vld_ff ? skid_bright_ff : bright_ff;
   assign rsp_degenerate = skid_vld_ff ? skid_degen_ff  : degen_ff;

endmodule

/* rtl/ffls_isqrt.sv */
// ----------------------------------------------------------------------------
// ffls_isqrt: pipelined integer square root
// Floor of the square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module ffls_isqrt import ffls_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  logic [SQ_IN_W-1:0]  x_in,
   output logic [SQ_OUT_W-1:0] root
);

   logic [SQ_W-1:0] rem_ff [SQ_STAGES];
   logic [SQ_W-1:0] r_ff   [SQ_STAGES];

   genvar k;
   generate
      for (k = 0; k < SQ_STAGES; k++) begin : g_stage
         localparam int SH = 2 * (SQ_STAGES - 1 - k);
         localparam logic [SQ_W-1:0] BITV = {{(SQ_W-1){1'b0}}, 1'b1} << SH;
         logic [SQ_W-1:0] rem_i, r_i, trial, rem_in, r_in;

         if (k == 0) begin : g_first
            assign rem_i = SQ_W'(x_in);
            assign r_i   = '0;
         end else begin : g_next
            assign rem_i = rem_ff[k-1];
            assign r_i   = r_ff[k-1];
         end

         always_comb begin
            trial = r_i + BITV;
            if (rem_i >= trial) begin
               rem_in = rem_i - trial;
               r_in   = (r_i >> 1) + BITV;
            end else begin
               rem_in = rem_i;
               r_in   = r_i >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               r_ff[k]   <= r_in;
            end
         end
      end
   endgenerate

   assign root = r_ff[SQ_STAGES-1][SQ_OUT_W-1:0];

endmodule

/* rtl/ffls_div.sv */
// ----------------------------------------------------------------------------
// ffls_div: pipelined restoring divider
// Magnitude quotient, one bit per stage; sign applied at the output.
// ----------------------------------------------------------------------------
module ffls_div import ffls_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  logic [DV_NUM_W-1:0] num,
   input  logic [DV_DEN_W-1:0] den,
   input  logic                neg,
   output quo_type             quo
);

   logic [DV_REM_W-1:0] rem_ff [DV_STAGES];
   logic [DV_DEN_W-1:0] den_ff [DV_STAGES];
   logic [DV_Q_W-1:0]   q_ff   [DV_STAGES];
   logic                neg_ff [DV_STAGES];

   genvar k;
   generate
      for (k = 0; k < DV_STAGES; k++) begin : g_stage
         localparam int SH = DV_Q_W - 1 - k;
         logic [DV_REM_W-1:0] rem_i, dsh, rem_in;
         logic [DV_DEN_W-1:0] den_i;
         logic [DV_Q_W-1:0]   q_i, q_in;
         logic                neg_i, ge;

         if (k == 0) begin : g_first
            assign rem_i = DV_REM_W'(num);
            assign den_i = den;
            assign q_i   = '0;
            assign neg_i = neg;
         end else begin : g_next
            assign rem_i = rem_ff[k-1];
            assign den_i = den_ff[k-1];
            assign q_i   = q_ff[k-1];
            assign neg_i = neg_ff[k-1];
         end

         always_comb begin
            dsh    = DV_REM_W'(den_i) << SH;
            ge     = (rem_i >= dsh);
            rem_in = ge ? (rem_i - dsh) : rem_i;
            q_in   = {q_i[DV_Q_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_i;
               q_ff[k]   <= q_in;
               neg_ff[k] <= neg_i;
            end
         end
      end
   endgenerate

   assign quo = neg_ff[DV_STAGES-1] ? -quo_type'({1'b0, q_ff[DV_STAGES-1]})
                                    :  quo_type'({1'b0, q_ff[DV_STAGES-1]});

endmodule

/* rtl/ffls_chk.sv */
// ----------------------------------------------------------------------------
// ffls_chk: port-level checks for flat_face_lambert_shade
// Watches the request and response handshakes over time.
// ----------------------------------------------------------------------------
module ffls_chk import ffls_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [BRIGHT_W-1:0] rsp_brightness,
   input logic                rsp_degenerate
);

   // a stalled result holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_brightness)
                                  && $stable(rsp_degenerate))
      else $error("stalled result changed");

   // reset empties the pipeline and opens the input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // input only closes after a stalled result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("input closed without an output stall");

   // draining the held result reopens the input
   a_ready_reopen: assert property (@(posedge clock) disable iff (reset)
      !req_ready && rsp_valid && rsp_ready |=> req_ready)
      else $error("input stayed closed after transfer");

endmodule

bind flat_face_lambert_shade ffls_chk u_ffls_chk (.*);
